[rtl/cfbx_pkg.sv]
package cfbx_pkg;

   localparam int unsigned MaxBeats = 6;
   localparam int unsigned CountWidth = $clog2(MaxBeats + 1);

   localparam logic [7:0] StartByteReset = 8'h02;
   localparam logic [7:0] DataModeMinLow = 8'd30;

   localparam logic OpBegin   = 1'b0;
   localparam logic OpPayload = 1'b1;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } beat_type;

   // Beats of one item, entry 0 goes out first.
   typedef struct packed {
      beat_type [MaxBeats-1:0]  beats;
      logic [CountWidth-1:0]    count;
   } beat_list_type;

endpackage

[rtl/cfbx_frame_core.sv]
module cfbx_frame_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [7:0]             csr_wr_data,
   input  logic                   accept,
   input  logic                   op,
   input  logic [7:0]             command,
   input  logic [15:0]            frame_length,
   input  logic [7:0]             setting_index,
   input  logic [7:0]             data_byte,
   output cfbx_pkg::beat_list_type beat_list
);
   import cfbx_pkg::*;

   logic [7:0]  start_byte_ff;
   logic        frame_open_ff, frame_open_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [7:0]  xor_ff, xor_in;

   logic [7:0]  len_lo, len_hi;
   logic [7:0]  head_xor;
   logic [7:0]  pay_xor;
   logic [15:0] rem_dec;

   assign len_lo   = frame_length[7:0];
   assign len_hi   = frame_length[15:8];
   assign head_xor = start_byte_ff ^ command ^ len_lo ^ len_hi;
   assign pay_xor  = xor_ff ^ data_byte;
   assign rem_dec  = (remaining_ff != 16'd0) ? remaining_ff - 16'd1 : 16'd0;

   always_comb begin
      beat_list     = '0;
      frame_open_in = frame_open_ff;
      remaining_in  = remaining_ff;
      xor_in        = xor_ff;
      case (op)
         OpBegin: begin
            beat_list.beats[0] = '{frame_byte: start_byte_ff, last_byte: 1'b0};
            beat_list.beats[1] = '{frame_byte: command, last_byte: 1'b0};
            beat_list.beats[2] = '{frame_byte: len_lo, last_byte: 1'b0};
            beat_list.beats[3] = '{frame_byte: len_hi, last_byte: 1'b0};
            frame_open_in = 1'b0;
            remaining_in  = 16'd0;
            xor_in        = 8'd0;
            if (frame_length == 16'd0) begin
               beat_list.beats[4] = '{frame_byte: head_xor, last_byte: 1'b1};
               beat_list.count    = CountWidth'(5);
            end else if (frame_length == 16'd1) begin
               beat_list.beats[4] = '{frame_byte: setting_index, last_byte: 1'b0};
               beat_list.beats[5] = '{frame_byte: head_xor ^ setting_index,
                                      last_byte: 1'b1};
               beat_list.count    = CountWidth'(6);
            end else if (len_hi == 8'd0 && len_lo > DataModeMinLow) begin
               // data mode: payload carries the whole length
               beat_list.count = CountWidth'(4);
               frame_open_in   = 1'b1;
               remaining_in    = frame_length;
               xor_in          = head_xor;
            end else begin
               beat_list.beats[4] = '{frame_byte: setting_index, last_byte: 1'b0};
               beat_list.count    = CountWidth'(5);
               frame_open_in      = 1'b1;
               remaining_in       = frame_length - 16'd1;
               xor_in             = head_xor ^ setting_index;
            end
         end
         OpPayload: begin
            if (frame_open_ff) begin
               beat_list.beats[0] = '{frame_byte: data_byte, last_byte: 1'b0};
               if (rem_dec == 16'd0) begin
                  beat_list.beats[1] = '{frame_byte: pay_xor, last_byte: 1'b1};
                  beat_list.count    = CountWidth'(2);
                  frame_open_in      = 1'b0;
                  remaining_in       = 16'd0;
                  xor_in             = 8'd0;
               end else begin
                  beat_list.count = CountWidth'(1);
                  remaining_in    = rem_dec;
                  xor_in          = pay_xor;
               end
            end
         end
         default: begin
            beat_list = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= StartByteReset;
         frame_open_ff <= 1'b0;
         remaining_ff  <= 16'd0;
         xor_ff        <= 8'd0;
      end else begin
         if (csr_wr_en) begin
            start_byte_ff <= csr_wr_data;
         end
         if (accept) begin
            frame_open_ff <= frame_open_in;
            remaining_ff  <= remaining_in;
            xor_ff        <= xor_in;
         end
      end
   end

endmodule

[rtl/cfbx_beat_queue.sv]
module cfbx_beat_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  cfbx_pkg::beat_list_type beat_list,
   output logic                    can_load,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_frame_byte,
   output logic                    rsp_last_byte
);
   import cfbx_pkg::*;

   beat_type [MaxBeats-1:0] beats_ff, beats_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    taken;

   assign rsp_valid      = (count_ff != '0);
   assign rsp_frame_byte = beats_ff[0].frame_byte;
   assign rsp_last_byte  = beats_ff[0].last_byte;
   assign taken          = rsp_valid && !rsp_stall;
   // free now, or the final beat leaves this cycle
   assign can_load = (count_ff == '0) || (count_ff == CountWidth'(1) && taken);

   always_comb begin
      beats_in = beats_ff;
      count_in = count_ff;
      if (load) begin
         beats_in = beat_list.beats;
         count_in = beat_list.count;
      end else if (taken) begin
         for (int i = 0; i < MaxBeats - 1; i++) begin
            beats_in[i] = beats_ff[i+1];
         end
         beats_in[MaxBeats-1] = '0;
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      beats_ff <= beats_in;
   end

endmodule

[rtl/command_frame_builder_xor.sv]
// Command frame builder with XOR checksum.
//
// Input channel (req_*): one beat is either a frame begin (req_op = 0,
// with command, 16-bit length and setting index) or one payload byte
// (req_op = 1). Result channel (rsp_*): the frame bytes in transmit order,
// rsp_last_byte marks the closing checksum. csr_wr_en/csr_wr_data write
// the start-of-frame byte (0x02 after reset); write it only while idle.
//
// Latency: the first byte of an item appears the cycle after it is taken.
// Throughput: an item produces 4 to 6 bytes for a begin, 1 or 2 for a
// payload byte and none for a dropped byte; the output shift queue sends
// one beat per cycle while rsp_stall is low, and the next item is taken
// in the same cycle the previous item's final byte leaves.
//
// Reset (synchronous): no frame open, queue empty, running XOR cleared.
// While rsp_stall is high the current byte holds. req_stall is low only
// while the queue is empty or its final byte leaves in that cycle, so a
// stalled final byte also holds off the next request beat.
module command_frame_builder_xor (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_op,
   input  logic [7:0] req_command,
   input  logic [15:0] req_frame_length,
   input  logic [7:0] req_setting_index,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_frame_byte,
   output logic       rsp_last_byte
);
   import cfbx_pkg::*;

   beat_list_type beat_list;
   logic          can_load;
   logic          accept;

   assign req_stall = !can_load;
   assign accept    = req_valid && can_load;

   // Frame state and per-item byte list.
   cfbx_frame_core u_core (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .accept        (accept),
      .op            (req_op),
      .command       (req_command),
      .frame_length  (req_frame_length),
      .setting_index (req_setting_index),
      .data_byte     (req_data_byte),
      .beat_list     (beat_list)
   );

   // Registered output queue, one byte per beat.
   cfbx_beat_queue u_queue (
      .clock          (clock),
      .reset          (reset),
      .load           (accept),
      .beat_list      (beat_list),
      .can_load       (can_load),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule
